// ===== rtl/sstu_pkg.sv =====
// Shared types, constants and the sine table builder for the stereo sine bank.
package sstu_pkg;

  // Default sizes for the top level parameters
  localparam int OSC_COUNT_DEF   = 40;
  localparam int SINE_DEPTH_DEF  = 1024;
  localparam int PHASE_BITS_DEF  = 32;

  // Fixed field widths
  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 6;
  localparam int STEP_W   = 32;
  localparam int LEVEL_W  = 16;
  localparam int SAMPLE_W = 24;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 2 * SAMPLE_W;

  // Datapath widths
  localparam int SIN_W      = 16;
  localparam int CSIN_W     = 17;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int TREM_SHIFT = 15;
  localparam int GAIN_SHIFT = 22;
  localparam int TERM_W     = 26;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd4096;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Function codes of an input word
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_CAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WR_LFO = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CIDX,
    ST_LIDX,
    ST_CSIN,
    ST_LSIN,
    ST_TREM,
    ST_GAIN,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MUL_IDX_C,
    MUL_IDX_L,
    MUL_SQR,
    MUL_TREM,
    MUL_GAIN
  } mul_op_e;

  typedef struct packed {
    logic    en;
    mul_op_e op;
  } mul_ctrl_t;

  // Quarter-wave entry from a Q2.30 angle: truncated Taylor series, Q1.15 result
  function automatic logic [SIN_W-1:0] sine_from_angle(longint unsigned a);
    longint unsigned one;
    longint unsigned a2;
    longint unsigned t;
    longint unsigned s;
    one = 64'd1 << 30;
    a2  = (a * a) >> 30;
    t   = one;
    t   = one - (((a2 * t) >> 30) / 64'd110);
    t   = one - (((a2 * t) >> 30) / 64'd72);
    t   = one - (((a2 * t) >> 30) / 64'd42);
    t   = one - (((a2 * t) >> 30) / 64'd20);
    t   = one - (((a2 * t) >> 30) / 64'd6);
    s   = (a * t) >> 30;
    return SIN_W'((s * 64'd32767 + (64'd1 << 29)) >> 30);
  endfunction

endpackage

// ===== rtl/sstu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sstu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sstu_sine_rom.sv =====
// Quarter-wave sine ROM, entries 0..depth, registered read.
module sstu_sine_rom #(
  parameter int SINE_TABLE_DEPTH = sstu_pkg::SINE_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr_i,
  output logic [sstu_pkg::SIN_W-1:0]            data_o
);
  import sstu_pkg::*;

  logic [SIN_W-1:0] rom [SINE_TABLE_DEPTH+1];
  logic [SIN_W-1:0] data_q;

  // table contents fixed at elaboration
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
    localparam longint unsigned Angle =
      (longint'(g) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    assign rom[g] = sine_from_angle(Angle);
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule

// ===== rtl/sstu_mul.sv =====
// Shared multiplier: operand select, one signed multiply, registered product.
module sstu_mul #(
  parameter int PHASE_BITS       = sstu_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = sstu_pkg::SINE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  sstu_pkg::mul_ctrl_t                 ctrl_i,
  input  logic [PHASE_BITS-1:0]               car_phase_i,
  input  logic [PHASE_BITS-1:0]               lfo_phase_i,
  input  logic [sstu_pkg::SIN_W-1:0]          sin_i,
  input  logic signed [sstu_pkg::CSIN_W-1:0]  csin_i,
  input  logic [sstu_pkg::LEVEL_W-1:0]        level_i,
  output logic signed [sstu_pkg::PROD_W-1:0]  prod_o
);
  import sstu_pkg::*;

  // phase times four table depths gives the table index above PHASE_BITS
  localparam logic signed [MUL_B_W-1:0] QUAD_SCALE = MUL_B_W'(4 * SINE_TABLE_DEPTH);

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  prod_q;

  // operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.op)
      MUL_IDX_C: begin
        mul_a = MUL_A_W'(car_phase_i);
        mul_b = QUAD_SCALE;
      end
      MUL_IDX_L: begin
        mul_a = MUL_A_W'(lfo_phase_i);
        mul_b = QUAD_SCALE;
      end
      MUL_SQR: begin
        mul_a = MUL_A_W'(sin_i);
        mul_b = MUL_B_W'(sin_i);
      end
      MUL_TREM: begin
        mul_a = MUL_A_W'(csin_i);
        mul_b = MUL_B_W'(prod_q[TREM_SHIFT +: CSIN_W]);
      end
      MUL_GAIN: begin
        mul_a = prod_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(level_i);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/stereo_sine_bank_with_lfo_tremolo_unit.sv =====
// Tick: one tick at a time; the input is not ready until the result is loaded into the output register.
// Each oscillator runs five products through the one shared multiplier and
// two lookups through the single sine ROM port.
// Step writes give no output word; the input stays ready after them.
// Reset (async, active low) clears state, valid bits and level (4096); no clearing pass.
// Phase and step entries read as zero until written, via per-entry valid bits.
module stereo_sine_bank_with_lfo_tremolo_unit #(
  parameter int OSC_COUNT        = sstu_pkg::OSC_COUNT_DEF,
  parameter int SINE_TABLE_DEPTH = sstu_pkg::SINE_DEPTH_DEF,
  parameter int PHASE_BITS       = sstu_pkg::PHASE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // stream in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sstu_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // osc_index[5:0], phase_step[37:6]
  input  logic [sstu_pkg::FUNC_W-1:0]         s_axis_tuser,  // func[1:0]
  // stream out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sstu_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // left_sample[23:0], right_sample[47:24]
  // level register write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sstu_pkg::LEVEL_W-1:0]        cfg_data_i
);
  import sstu_pkg::*;

  localparam int OSC_W = $clog2(OSC_COUNT);
  localparam int I_W   = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int A_W   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int ACC_W = TERM_W + $clog2(OSC_COUNT);

  localparam logic [OSC_W-1:0] LAST_OSC = OSC_W'(OSC_COUNT - 1);
  localparam logic [I_W-1:0]   QUAD1    = I_W'(SINE_TABLE_DEPTH);
  localparam logic [I_W-1:0]   QUAD2    = I_W'(2 * SINE_TABLE_DEPTH);
  localparam logic [I_W-1:0]   QUAD3    = I_W'(3 * SINE_TABLE_DEPTH);
  localparam logic [A_W-1:0]   TOP_ADDR = A_W'(SINE_TABLE_DEPTH);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-8388608);

  state_e state_q, state_d;
  logic [OSC_W-1:0] k_q, k_d;

  logic [LEVEL_W-1:0]   level_q;
  logic [OSC_COUNT-1:0] phase_vld_q;
  logic [OSC_COUNT-1:0] cstep_vld_q;
  logic [OSC_COUNT-1:0] lstep_vld_q;
  logic                 out_valid_q;

  logic [PHASE_BITS-1:0]    lp_q;
  logic                     neg_q;
  logic signed [CSIN_W-1:0] csin_q;
  logic signed [ACC_W-1:0]  acc_l_q, acc_r_q;
  logic [SAMPLE_W-1:0]      left_q, right_q;

  // input word fields
  logic [IDX_W-1:0]  in_idx;
  logic [STEP_W-1:0] in_step;
  logic              in_acc;
  logic              wr_ok;
  logic [OSC_W-1:0]  wr_addr;

  assign in_idx  = s_axis_tdata[IDX_W-1:0];
  assign in_step = s_axis_tdata[IDX_W +: STEP_W];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign wr_ok   = in_acc && (32'(in_idx) < 32'(OSC_COUNT));
  assign wr_addr = OSC_W'(in_idx);

  // RAM signals
  logic                  rd_en;
  logic [OSC_W-1:0]      rd_addr;
  logic                  ph_we;
  logic [PHASE_BITS-1:0] cp_raw, lp_raw, cs_raw, ls_raw;
  logic [PHASE_BITS-1:0] cp_m, lp_m, cs_m, ls_m;
  logic [PHASE_BITS-1:0] cp_new, lp_new;

  // unwritten entries read as zero
  assign cp_m   = phase_vld_q[k_q] ? cp_raw : '0;
  assign lp_m   = phase_vld_q[k_q] ? lp_raw : '0;
  assign cs_m   = cstep_vld_q[k_q] ? cs_raw : '0;
  assign ls_m   = lstep_vld_q[k_q] ? ls_raw : '0;
  assign cp_new = cp_m + cs_m;
  assign lp_new = lp_m + ls_m;

  sstu_ram #(.WIDTH(PHASE_BITS), .DEPTH(OSC_COUNT)) u_car_phase (
    .clk_i, .we_i(ph_we), .waddr_i(k_q), .wdata_i(cp_new),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(cp_raw)
  );

  sstu_ram #(.WIDTH(PHASE_BITS), .DEPTH(OSC_COUNT)) u_lfo_phase (
    .clk_i, .we_i(ph_we), .waddr_i(k_q), .wdata_i(lp_new),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(lp_raw)
  );

  sstu_ram #(.WIDTH(PHASE_BITS), .DEPTH(OSC_COUNT)) u_car_step (
    .clk_i, .we_i(wr_ok && (s_axis_tuser == FUNC_WR_CAR)), .waddr_i(wr_addr),
    .wdata_i(in_step[PHASE_BITS-1:0]),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(cs_raw)
  );

  sstu_ram #(.WIDTH(PHASE_BITS), .DEPTH(OSC_COUNT)) u_lfo_step (
    .clk_i, .we_i(wr_ok && (s_axis_tuser == FUNC_WR_LFO)), .waddr_i(wr_addr),
    .wdata_i(in_step[PHASE_BITS-1:0]),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(ls_raw)
  );

  // shared multiplier
  mul_ctrl_t                mul_ctrl;
  logic signed [PROD_W-1:0] prod;
  logic [SIN_W-1:0]         rom_data;

  sstu_mul #(.PHASE_BITS(PHASE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_mul (
    .clk_i,
    .ctrl_i      (mul_ctrl),
    .car_phase_i (cp_m),
    .lfo_phase_i (lp_q),
    .sin_i       (rom_data),
    .csin_i      (csin_q),
    .level_i     (level_q),
    .prod_o      (prod)
  );

  // table index from the product: quadrant, mirror and sign
  logic [I_W-1:0] tab_idx;
  logic [I_W-1:0] tab_rem;
  logic           tab_mirror;
  logic           tab_neg;
  logic [A_W-1:0] rom_addr;

  assign tab_idx = prod[PHASE_BITS +: I_W];

  always_comb begin
    tab_rem    = tab_idx;
    tab_mirror = 1'b0;
    tab_neg    = 1'b0;
    if (tab_idx >= QUAD3) begin
      tab_rem    = tab_idx - QUAD3;
      tab_mirror = 1'b1;
      tab_neg    = 1'b1;
    end else if (tab_idx >= QUAD2) begin
      tab_rem    = tab_idx - QUAD2;
      tab_neg    = 1'b1;
    end else if (tab_idx >= QUAD1) begin
      tab_rem    = tab_idx - QUAD1;
      tab_mirror = 1'b1;
    end
    rom_addr = tab_mirror ? (TOP_ADDR - A_W'(tab_rem)) : A_W'(tab_rem);
  end

  sstu_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
    .clk_i,
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // sequencer: next state and strobes
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    rd_en    = 1'b0;
    rd_addr  = k_q;
    ph_we    = 1'b0;
    mul_ctrl = '{en: 1'b0, op: MUL_IDX_C};
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == FUNC_TICK)) begin
          state_d = ST_RD;
          k_d     = '0;
        end
      end
      ST_RD: begin
        rd_en   = 1'b1;
        state_d = ST_CIDX;
      end
      ST_CIDX: begin
        mul_ctrl = '{en: 1'b1, op: MUL_IDX_C};
        ph_we    = 1'b1;
        state_d  = ST_LIDX;
      end
      ST_LIDX: begin
        mul_ctrl = '{en: 1'b1, op: MUL_IDX_L};
        state_d  = ST_CSIN;
      end
      ST_CSIN: begin
        state_d = ST_LSIN;
      end
      ST_LSIN: begin
        mul_ctrl = '{en: 1'b1, op: MUL_SQR};
        state_d  = ST_TREM;
      end
      ST_TREM: begin
        mul_ctrl = '{en: 1'b1, op: MUL_TREM};
        state_d  = ST_GAIN;
      end
      ST_GAIN: begin
        mul_ctrl = '{en: 1'b1, op: MUL_GAIN};
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        if (k_q == LAST_OSC) begin
          state_d = ST_DONE;
        end else begin
          // fetch the next oscillator while this term is summed
          rd_en   = 1'b1;
          rd_addr = k_q + 1'b1;
          k_d     = k_q + 1'b1;
          state_d = ST_CIDX;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      level_q     <= LEVEL_RESET;
      phase_vld_q <= '0;
      cstep_vld_q <= '0;
      lstep_vld_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (cfg_valid_i && cfg_ready_o) begin
        level_q <= cfg_data_i;
      end
      if (ph_we) begin
        phase_vld_q[k_q] <= 1'b1;
      end
      if (wr_ok && (s_axis_tuser == FUNC_WR_CAR)) begin
        cstep_vld_q[wr_addr] <= 1'b1;
      end
      if (wr_ok && (s_axis_tuser == FUNC_WR_LFO)) begin
        lstep_vld_q[wr_addr] <= 1'b1;
      end
      if ((state_q == ST_DONE) && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // term of the current oscillator, floored
  logic signed [TERM_W-1:0] term;
  assign term = prod[GAIN_SHIFT +: TERM_W];

  function automatic logic [SAMPLE_W-1:0] saturate(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end
    return c[SAMPLE_W-1:0];
  endfunction

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        acc_l_q <= '0;
        acc_r_q <= '0;
      end
      ST_CIDX: begin
        lp_q <= lp_m;
      end
      ST_LIDX: begin
        neg_q <= tab_neg;
      end
      ST_CSIN: begin
        csin_q <= neg_q ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
      end
      ST_ACC: begin
        if (k_q[0]) begin
          acc_r_q <= acc_r_q + ACC_W'(term);
        end else begin
          acc_l_q <= acc_l_q + ACC_W'(term);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          left_q  <= saturate(acc_l_q);
          right_q <= saturate(acc_r_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {right_q, left_q};
  assign cfg_ready_o   = 1'b1;

endmodule

// ===== rtl/sstu_checker.sv =====
// Port-level checks on the stereo sine bank, bound to the top level.
module sstu_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [sstu_pkg::FUNC_W-1:0]       s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [sstu_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import sstu_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a tick occupies the sequencer
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser == FUNC_TICK)) |=> !s_axis_tready)
    else $error("input still ready after a tick word");

  // step writes and unused codes leave the input ready
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser != FUNC_TICK)) |=> s_axis_tready)
    else $error("input not ready after a non-tick word");

  // a new sample appears as the sequencer returns to idle
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("output word raised while busy");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output word changed");

endmodule

bind stereo_sine_bank_with_lfo_tremolo_unit sstu_checker u_sstu_checker (.*);

// ===== tb/tb_stereo_sine_bank_with_lfo_tremolo_unit.sv =====
// Self-checking testbench for the stereo sine bank with LFO tremolo.
`timescale 1ns / 1ps

module tb_stereo_sine_bank_with_lfo_tremolo_unit;

  localparam int NOSC    = sstu_pkg::OSC_COUNT_DEF;
  localparam int TBL_D   = sstu_pkg::SINE_DEPTH_DEF;
  localparam int PH_BITS = sstu_pkg::PHASE_BITS_DEF;
  localparam int DRAIN_CYCLES = 300;  // settling wait after the last owed sample
  localparam int MAX_PRINTED  = 40;   // mismatch lines shown; all are counted
  localparam logic [sstu_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [sstu_pkg::SAMPLE_W-1:0] right;
    logic [sstu_pkg::SAMPLE_W-1:0] left;
  } stereo_t;

  // Mirror of the oscillator bank: phases, steps, level and the samples still owed
  class sine_bank_mirror;
    int        quarter_wave[TBL_D+1];
    bit [31:0] car_phase[NOSC];
    bit [31:0] lfo_phase[NOSC];
    bit [31:0] car_step[NOSC];
    bit [31:0] lfo_step[NOSC];
    int        level_q16;
    stereo_t   pending_samples[$];
    int        errors;
    int        n_ticks;
    int        n_writes;
    int        n_ignored;
    int        n_checked;

    function new();
      longint unsigned a, a2, t, s;
      longint unsigned series_div[5];
      series_div = '{110, 72, 42, 20, 6};
      // Q1.15 quarter wave from a truncated Taylor series on a Q2.30 angle
      for (int r = 0; r <= TBL_D; r++) begin
        a  = longint'(r) * sstu_pkg::HALF_PI_Q30 / TBL_D;
        a2 = (a * a) >> 30;
        t  = 64'd1 << 30;
        foreach (series_div[k]) t = (64'd1 << 30) - (((a2 * t) >> 30) / series_div[k]);
        s  = (a * t) >> 30;
        quarter_wave[r] = int'((s * 32767 + (64'd1 << 29)) >> 30);
      end
      level_q16 = sstu_pkg::LEVEL_RESET;
      foreach (car_phase[k]) begin
        car_phase[k] = '0;
        lfo_phase[k] = '0;
        car_step[k]  = '0;
        lfo_step[k]  = '0;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Full sine from a phase: quadrant picks mirror and sign
    function int sine_of(bit [31:0] p);
      longint unsigned i;
      int unsigned r;
      i = (longint'(p) * 4 * TBL_D) >> PH_BITS;
      r = i % TBL_D;
      case ((i / TBL_D) % 4)
        0:       return quarter_wave[r];
        1:       return quarter_wave[TBL_D - r];
        2:       return -quarter_wave[r];
        default: return -quarter_wave[TBL_D - r];
      endcase
    endfunction

    function logic [23:0] clip24(longint v);
      if (v > 64'sd8388607) return 24'h7FFFFF;
      if (v < -64'sd8388608) return 24'h800000;
      return v[23:0];
    endfunction

    // Apply one accepted input word; a tick owes one stereo sample
    function void take_word(logic [1:0] func, logic [5:0] idx, logic [31:0] step);
      longint  acc[2];
      longint  c, l, g;
      stereo_t smp;
      case (func)
        sstu_pkg::FUNC_TICK: begin
          n_ticks++;
          acc[0] = 0;
          acc[1] = 0;
          for (int k = 0; k < NOSC; k++) begin
            c = sine_of(car_phase[k]);
            l = sine_of(lfo_phase[k]);
            g = (l * l) >>> 15;
            // arithmetic shift floors toward minus infinity
            acc[k % 2] += (c * g * longint'(level_q16)) >>> 22;
            car_phase[k] += car_step[k];
            lfo_phase[k] += lfo_step[k];
          end
          smp.left  = clip24(acc[0]);
          smp.right = clip24(acc[1]);
          pending_samples.push_back(smp);
        end
        sstu_pkg::FUNC_WR_CAR, sstu_pkg::FUNC_WR_LFO: begin
          if (idx >= NOSC) begin
            n_ignored++;
          end else begin
            n_writes++;
            if (func == sstu_pkg::FUNC_WR_CAR) car_step[idx] = step;
            else lfo_step[idx] = step;
          end
        end
        default: n_ignored++;
      endcase
    endfunction

    task check_sample(logic [47:0] word);
      stereo_t want;
      if (pending_samples.size() == 0) begin
        report($sformatf("sample L=%0d R=%0d arrived with none pending",
                         $signed(word[23:0]), $signed(word[47:24])));
        return;
      end
      want = pending_samples.pop_front();
      n_checked++;
      if (word[23:0] !== want.left)
        report($sformatf("sample %0d left got %0d want %0d", n_checked,
                         $signed(word[23:0]), $signed(want.left)));
      if (word[47:24] !== want.right)
        report($sformatf("sample %0d right got %0d want %0d", n_checked,
                         $signed(word[47:24]), $signed(want.right)));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // osc_index[5:0], phase_step[37:6]
  logic [1:0]  s_axis_tuser;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;   // left_sample[23:0], right_sample[47:24]
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  sine_bank_mirror board = new();
  int tx_idle_pct = 33;
  int rx_idle_pct = 65;
  int n_levels;

  stereo_sine_bank_with_lfo_tremolo_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Output words are sampled on the falling edge before the rising edge that takes them
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_sample(m_axis_tdata);
  end

  initial begin
    #2_000_000;
    $display("tb_stereo_sine_bank_with_lfo_tremolo_unit: FAIL");
    $finish;
  end

  // One input word, with a random gap ahead of it
  task automatic send_word(input logic [1:0] func, input logic [5:0] idx,
                           input logic [31:0] step);
    bit taken;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {2'b00, step, idx};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    board.take_word(func, idx, step);
  endtask

  task automatic send_random_word();
    int unsigned pick;
    logic [1:0]  func;
    logic [5:0]  idx;
    logic [31:0] step;
    pick = $urandom_range(99);
    if (pick < 45)      func = sstu_pkg::FUNC_TICK;
    else if (pick < 70) func = sstu_pkg::FUNC_WR_CAR;
    else if (pick < 95) func = sstu_pkg::FUNC_WR_LFO;
    else                func = FUNC_UNUSED;
    // mostly valid oscillators, a few out of range
    idx = ($urandom_range(99) < 90) ? 6'($urandom_range(NOSC - 1)) : 6'($urandom_range(63, NOSC));
    case ($urandom_range(3))
      0:       step = $urandom_range(32'h000F_FFFF);  // slow, audio-like rates
      3:       step = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: step = $urandom();
    endcase
    send_word(func, idx, step);
  endtask

  // Hold the sender until every owed sample is out and the bank has settled
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (board.pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_level(input logic [15:0] value);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    board.level_q16 = value;
    n_levels++;
  endtask

  initial begin
    int unsigned level_plan[6];
    int          goal;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = sstu_pkg::FUNC_TICK;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    level_plan = '{16'hFFFF, 0, $urandom_range(65535), 1, 32768, $urandom_range(65535)};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: silent bank, quarter-turn steps, extreme steps, ignored words
    send_word(sstu_pkg::FUNC_TICK,   6'd0,  32'h0);
    send_word(sstu_pkg::FUNC_WR_CAR, 6'd0,  32'h4000_0000);
    send_word(sstu_pkg::FUNC_WR_LFO, 6'd0,  32'h4000_0000);
    send_word(sstu_pkg::FUNC_WR_CAR, 6'd1,  32'hC000_0000);
    send_word(sstu_pkg::FUNC_WR_LFO, 6'd1,  32'h4000_0000);
    send_word(sstu_pkg::FUNC_WR_CAR, 6'd38, 32'hFFFF_FFFF);
    send_word(sstu_pkg::FUNC_WR_LFO, 6'd38, 32'hFFFF_FFFF);
    send_word(sstu_pkg::FUNC_WR_CAR, 6'd39, 32'h0);
    send_word(sstu_pkg::FUNC_WR_LFO, 6'd39, 32'h8000_0000);
    send_word(sstu_pkg::FUNC_TICK,   6'd0,  32'h0);
    // out-of-range oscillator writes and the unused code must leave the bank alone
    send_word(sstu_pkg::FUNC_WR_CAR, 6'd40, 32'h1234_5678);
    send_word(sstu_pkg::FUNC_WR_LFO, 6'd63, 32'hFFFF_FFFF);
    send_word(FUNC_UNUSED,           6'd63, 32'hFFFF_FFFF);
    send_word(FUNC_UNUSED,           6'd0,  32'h0);
    // tick ignores its index and step fields
    send_word(sstu_pkg::FUNC_TICK,   6'd63, 32'hFFFF_FFFF);
    send_word(sstu_pkg::FUNC_TICK,   6'd21, 32'hA5A5_5A5A);
    send_word(sstu_pkg::FUNC_TICK,   6'd0,  32'h0);
    wait_quiet();

    // Random phases: idle pattern changes every two phases, level every phase
    for (int ph = 0; ph < 6; ph++) begin
      tx_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 65 : 0;
      rx_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 33 : 0;
      set_level(16'(level_plan[ph]));
      goal = board.n_ticks + board.n_writes + board.n_ignored + 105;
      while (board.n_ticks + board.n_writes + board.n_ignored < goal) send_random_word();
      wait_quiet();
    end

    $display("covered %0d ticks (%0d samples checked), %0d step writes, %0d ignored words",
             board.n_ticks, board.n_checked, board.n_writes, board.n_ignored);
    $display("across %0d level settings including 0 and 65535 and three idle patterns",
             n_levels);
    if (board.errors == 0) begin
      $display("tb_stereo_sine_bank_with_lfo_tremolo_unit: PASS");
    end else begin
      $display("tb_stereo_sine_bank_with_lfo_tremolo_unit: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sstu_pkg.sv
rtl/sstu_ram.sv
rtl/sstu_sine_rom.sv
rtl/sstu_mul.sv
rtl/stereo_sine_bank_with_lfo_tremolo_unit.sv
rtl/sstu_checker.sv
tb/tb_stereo_sine_bank_with_lfo_tremolo_unit.sv
